[rtl/irpd_pkg.sv]
// Shared types, widths and constants for the IR pulse-distance decoder.
// No dependencies; the window and top-level modules import it.
package irpd_pkg;

  localparam int DATA_BITS = 8;
  localparam int VALUE_W   = 8;
  localparam int DUR_W     = 16;
  localparam int TOL_W     = 7;
  localparam int EXCESS_W  = 10;
  localparam int NOM_W     = DUR_W + 1;
  localparam int FACTOR_W  = 8;
  localparam int PROD_W    = 25;
  localparam int POS_W     = $clog2(2 * DATA_BITS + 2);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TOL_W-1:0]  PCT_FULL = TOL_W'(100);
  localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);
  localparam logic [PROD_W-1:0] PCT_ROUND = PROD_W'(99);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXCESS    = 3'd6;

  // Reset values of the registers
  localparam logic [DUR_W-1:0]    RST_HDR_MARK   = 16'd6000;
  localparam logic [DUR_W-1:0]    RST_HDR_SPACE  = 16'd4500;
  localparam logic [DUR_W-1:0]    RST_BIT_MARK   = 16'd1000;
  localparam logic [DUR_W-1:0]    RST_ONE_SPACE  = 16'd2000;
  localparam logic [DUR_W-1:0]    RST_ZERO_SPACE = 16'd1000;
  localparam logic [TOL_W-1:0]    RST_TOLERANCE  = 7'd25;
  localparam logic [EXCESS_W-1:0] RST_EXCESS     = 10'd100;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HDR_MARK  = 3'd1,
    ST_HDR_SPACE = 3'd2,
    ST_BIT_MARK  = 3'd3,
    ST_BIT_SPACE = 3'd4
  } status_t;

  // Window bounds scaled by 100: a duration d matches when
  // lo <= 100*d + 99 and 100*d <= hi
  typedef struct packed {
    logic [PROD_W-1:0] lo;
    logic [PROD_W-1:0] hi;
  } win_t;

  function automatic logic in_window(input logic [DUR_W-1:0] d, input win_t w);
    logic [PROD_W-1:0] scaled;
    scaled = PROD_W'(d) * PCT_SCALE;
    return ((scaled + PCT_ROUND) >= w.lo) && (scaled <= w.hi);
  endfunction

endpackage

[rtl/irpd_window.sv]
// Scaled match window for one nominal length, registered.
// Depends on irpd_pkg for widths and the window type.
module irpd_window (
  input  logic                           clk,
  input  logic [irpd_pkg::DUR_W-1:0]     nominal,
  input  logic [irpd_pkg::EXCESS_W-1:0]  excess,
  input  logic [irpd_pkg::TOL_W-1:0]     tolerance,
  input  logic                           is_mark,
  output irpd_pkg::win_t                 bounds
);
  import irpd_pkg::*;

  logic [NOM_W-1:0]    adj_nom;
  logic [TOL_W-1:0]    tol_clamped;
  logic [FACTOR_W-1:0] lo_factor;
  logic [FACTOR_W-1:0] hi_factor;

  // Lengthen marks, shorten spaces with a floor at zero
  always_comb begin
    if (is_mark) begin
      adj_nom = NOM_W'(nominal) + NOM_W'(excess);
    end else if (nominal > DUR_W'(excess)) begin
      adj_nom = NOM_W'(nominal - DUR_W'(excess));
    end else begin
      adj_nom = '0;
    end
    tol_clamped = (tolerance > PCT_FULL) ? PCT_FULL : tolerance;
    lo_factor = FACTOR_W'(PCT_FULL) - FACTOR_W'(tol_clamped);
    hi_factor = FACTOR_W'(PCT_FULL) + FACTOR_W'(tol_clamped);
  end

  // Hold the scaled bounds for the decoder
  always_ff @(posedge clk) begin
    bounds.lo <= PROD_W'(adj_nom) * PROD_W'(lo_factor);
    bounds.hi <= PROD_W'(adj_nom) * PROD_W'(hi_factor);
  end

endmodule

[rtl/ir_pulse_distance_decoder.sv]
// IR pulse-distance frame decoder top level: config registers, frame state, result register.
// Depends on irpd_pkg and irpd_window.

// Takes one measured duration per word: a header mark (frame_start high), a header
// space, then eight bit-mark/bit-space pairs. A complete frame gives one result word
// with frame_ok high and the byte, first bit in the MSB; the first mismatch gives one
// result word with frame_ok low, data_value zero and a status code. Durations with no
// frame in progress and no start flag are dropped. The decoder takes one word per clock
// unless a result waits on out_ready, and the result is registered in the cycle after the
// word that ends the frame. Match windows are precomputed into registers from the
// configuration, so input is held off (in_ready low) in the cycle of a configuration write,
// the cycle after it, and the first cycle after reset, while those window registers reload.
module ir_pulse_distance_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [irpd_pkg::DUR_W-1:0]        duration_us,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              frame_ok,
  output logic [irpd_pkg::VALUE_W-1:0]      data_value,
  output logic [2:0]                        status,
  input  logic                              cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import irpd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * DATA_BITS + 1);
  localparam int EXT_W = (DATA_BITS > VALUE_W) ? DATA_BITS : VALUE_W;

  logic [DUR_W-1:0]    hdr_mark_us;
  logic [DUR_W-1:0]    hdr_space_us;
  logic [DUR_W-1:0]    bit_mark_us;
  logic [DUR_W-1:0]    one_space_us;
  logic [DUR_W-1:0]    zero_space_us;
  logic [TOL_W-1:0]    tolerance_pct;
  logic [EXCESS_W-1:0] mark_excess_us;

  win_t win_hdr_mark;
  win_t win_hdr_space;
  win_t win_bit_mark;
  win_t win_one_space;
  win_t win_zero_space;

  logic                 settle;
  logic                 frame_active;
  logic [POS_W-1:0]     position;
  logic [DATA_BITS-1:0] shift_data;

  logic                 frame_active_next;
  logic [POS_W-1:0]     position_next;
  logic [DATA_BITS-1:0] shift_data_next;
  logic                 emit;
  logic                 emit_ok;
  status_t              emit_status;
  logic [EXT_W-1:0]     shift_ext;
  logic                 accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_mark_us    <= RST_HDR_MARK;
      hdr_space_us   <= RST_HDR_SPACE;
      bit_mark_us    <= RST_BIT_MARK;
      one_space_us   <= RST_ONE_SPACE;
      zero_space_us  <= RST_ZERO_SPACE;
      tolerance_pct  <= RST_TOLERANCE;
      mark_excess_us <= RST_EXCESS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HDR_MARK:   hdr_mark_us    <= cfg_data;
        REG_HDR_SPACE:  hdr_space_us   <= cfg_data;
        REG_BIT_MARK:   bit_mark_us    <= cfg_data;
        REG_ONE_SPACE:  one_space_us   <= cfg_data;
        REG_ZERO_SPACE: zero_space_us  <= cfg_data;
        REG_TOLERANCE:  tolerance_pct  <= cfg_data[TOL_W-1:0];
        REG_EXCESS:     mark_excess_us <= cfg_data[EXCESS_W-1:0];
        default: ;
      endcase
    end
  end

  // Window registers, one per nominal length
  irpd_window u_win_hdr_mark (
    .clk(clk), .nominal(hdr_mark_us), .excess(mark_excess_us),
    .tolerance(tolerance_pct), .is_mark(1'b1), .bounds(win_hdr_mark)
  );
  irpd_window u_win_hdr_space (
    .clk(clk), .nominal(hdr_space_us), .excess(mark_excess_us),
    .tolerance(tolerance_pct), .is_mark(1'b0), .bounds(win_hdr_space)
  );
  irpd_window u_win_bit_mark (
    .clk(clk), .nominal(bit_mark_us), .excess(mark_excess_us),
    .tolerance(tolerance_pct), .is_mark(1'b1), .bounds(win_bit_mark)
  );
  irpd_window u_win_one_space (
    .clk(clk), .nominal(one_space_us), .excess(mark_excess_us),
    .tolerance(tolerance_pct), .is_mark(1'b0), .bounds(win_one_space)
  );
  irpd_window u_win_zero_space (
    .clk(clk), .nominal(zero_space_us), .excess(mark_excess_us),
    .tolerance(tolerance_pct), .is_mark(1'b0), .bounds(win_zero_space)
  );

  // Hold off input while the window registers reload
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_we;
    end
  end

  assign in_ready = !settle && !cfg_we && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Frame decode for the incoming word
  always_comb begin
    frame_active_next = frame_active;
    position_next     = position;
    shift_data_next   = shift_data;
    emit              = 1'b0;
    emit_ok           = 1'b0;
    emit_status       = ST_OK;
    if (frame_start) begin
      shift_data_next = '0;
      if (!in_window(duration_us, win_hdr_mark)) begin
        emit        = 1'b1;
        emit_status = ST_HDR_MARK;
      end else begin
        frame_active_next = 1'b1;
        position_next     = POS_W'(1);
      end
    end else if (frame_active) begin
      position_next = position + POS_W'(1);
      if (position == POS_W'(1)) begin
        if (!in_window(duration_us, win_hdr_space)) begin
          emit        = 1'b1;
          emit_status = ST_HDR_SPACE;
        end
      end else if (!position[0]) begin
        if (!in_window(duration_us, win_bit_mark)) begin
          emit        = 1'b1;
          emit_status = ST_BIT_MARK;
        end
      end else begin
        if (in_window(duration_us, win_one_space)) begin
          shift_data_next = {shift_data[DATA_BITS-2:0], 1'b1};
        end else if (in_window(duration_us, win_zero_space)) begin
          shift_data_next = {shift_data[DATA_BITS-2:0], 1'b0};
        end else begin
          emit        = 1'b1;
          emit_status = ST_BIT_SPACE;
        end
        if (!emit && position >= LAST_POS) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end
      end
    end
    // Any result ends the frame
    if (emit) begin
      frame_active_next = 1'b0;
      position_next     = '0;
    end
  end

  assign shift_ext = EXT_W'(shift_data_next);

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      position     <= '0;
      shift_data   <= '0;
    end else if (accept) begin
      frame_active <= frame_active_next;
      position     <= position_next;
      shift_data   <= shift_data_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frame_ok   <= emit_ok;
      data_value <= emit_ok ? shift_ext[VALUE_W-1:0] : '0;
      status     <= emit_status;
    end
  end

  // Checks on decoder state and results
  a_no_accept_in_settle: assert property (@(posedge clk) disable iff (rst)
    accept |-> !settle && !cfg_we)
    else $error("word accepted while window registers reload");

  a_active_has_position: assert property (@(posedge clk) disable iff (rst)
    frame_active == (position != '0))
    else $error("frame activity and position disagree");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= LAST_POS)
    else $error("position past the last bit space");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> status == ST_OK)
    else $error("complete frame with error status");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> data_value == '0 && status != ST_OK)
    else $error("error word carries data or ok status");

endmodule

[sim/irpd_checker.sv]
// Checker for the IR pulse-distance decoder: watches the config port and both word channels,
// predicts each result word and compares it field by field. Depends on irpd_pkg.
module irpd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [irpd_pkg::DUR_W-1:0]      duration_us,
  input  logic                            frame_start,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            frame_ok,
  input  logic [irpd_pkg::VALUE_W-1:0]    data_value,
  input  logic [2:0]                      status,
  input  logic                            cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              pending,
  output int                              errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import irpd_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
    status_t            code;
  } frame_reply_t;

  frame_reply_t replies_due[$];

  // Own copy of the registers and the frame state
  logic [DUR_W-1:0]    nom_hdr_mark, nom_hdr_space, nom_bit_mark, nom_one, nom_zero;
  logic [TOL_W-1:0]    tol_pct;
  logic [EXCESS_W-1:0] excess;
  int unsigned         slot;
  logic [VALUE_W-1:0]  shifted;
  bit                  in_frame;

  task automatic note_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // Window of +/- tolerance around an effective nominal, bounds floored
  function automatic bit fits(input logic [DUR_W-1:0] d, input int unsigned n);
    int unsigned t, lo, hi;
    t  = (tol_pct > PCT_FULL) ? 100 : tol_pct;
    lo = (n * (100 - t)) / 100;
    hi = (n * (100 + t)) / 100;
    return (d >= lo) && (d <= hi);
  endfunction

  function automatic bit fits_mark(input logic [DUR_W-1:0] d, input int unsigned nom);
    return fits(d, nom + excess);
  endfunction

  function automatic bit fits_space(input logic [DUR_W-1:0] d, input int unsigned nom);
    return fits(d, (nom > excess) ? nom - excess : 0);
  endfunction

  // Advance the frame by one accepted duration, queue a reply if the frame ends
  task automatic take_word(input logic [DUR_W-1:0] d, input logic start);
    frame_reply_t r;
    bit done;
    done    = 1'b0;
    r.ok    = 1'b0;
    r.value = '0;
    r.code  = ST_OK;
    if (start) begin
      shifted = '0;
      if (!fits_mark(d, nom_hdr_mark)) begin
        r.code = ST_HDR_MARK;
        done   = 1'b1;
      end else begin
        in_frame = 1'b1;
        slot     = 1;
      end
    end else if (in_frame) begin
      if (slot == 1) begin
        if (!fits_space(d, nom_hdr_space)) begin
          r.code = ST_HDR_SPACE;
          done   = 1'b1;
        end
      end else if (slot % 2 == 0) begin
        if (!fits_mark(d, nom_bit_mark)) begin
          r.code = ST_BIT_MARK;
          done   = 1'b1;
        end
      end else begin
        // one-length wins over zero-length where the windows overlap
        if (fits_space(d, nom_one)) begin
          shifted = {shifted[VALUE_W-2:0], 1'b1};
        end else if (fits_space(d, nom_zero)) begin
          shifted = {shifted[VALUE_W-2:0], 1'b0};
        end else begin
          r.code = ST_BIT_SPACE;
          done   = 1'b1;
        end
        if (!done && slot >= 1 + 2 * DATA_BITS) begin
          r.ok    = 1'b1;
          r.value = shifted;
          done    = 1'b1;
        end
      end
      if (!done) slot++;
    end
    if (done) begin
      replies_due.push_back(r);
      in_frame = 1'b0;
      slot     = 0;
    end
  endtask

  always @(posedge clk) begin
    frame_reply_t r;
    if (rst) begin
      nom_hdr_mark  = RST_HDR_MARK;
      nom_hdr_space = RST_HDR_SPACE;
      nom_bit_mark  = RST_BIT_MARK;
      nom_one       = RST_ONE_SPACE;
      nom_zero      = RST_ZERO_SPACE;
      tol_pct       = RST_TOLERANCE;
      excess        = RST_EXCESS;
      slot          = 0;
      shifted       = '0;
      in_frame      = 1'b0;
      errors        = 0;
      replies_due.delete();
    end else begin
      // Compare the result word with the oldest expectation
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          note_mismatch("result word with nothing expected");
        end else begin
          r = replies_due.pop_front();
          if (frame_ok !== r.ok)
            note_mismatch($sformatf("frame_ok %0b, want %0b", frame_ok, r.ok));
          if (data_value !== r.value)
            note_mismatch($sformatf("data_value %02h, want %02h", data_value, r.value));
          if (status !== r.code)
            note_mismatch($sformatf("status %0d, want %0d", status, r.code));
        end
      end
      // Track register writes; indexes past the list are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_HDR_MARK:   nom_hdr_mark  = cfg_data;
          REG_HDR_SPACE:  nom_hdr_space = cfg_data;
          REG_BIT_MARK:   nom_bit_mark  = cfg_data;
          REG_ONE_SPACE:  nom_one       = cfg_data;
          REG_ZERO_SPACE: nom_zero      = cfg_data;
          REG_TOLERANCE:  tol_pct       = cfg_data[TOL_W-1:0];
          REG_EXCESS:     excess        = cfg_data[EXCESS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_word(duration_us, frame_start);
    end
    pending = replies_due.size();
  end

endmodule

[sim/ir_pulse_distance_decoder_test.sv]
// Top of the IR pulse-distance decoder testbench: clock, reset, frame stimulus and verdict.
// Depends on irpd_pkg, the decoder RTL and irpd_checker.
module ir_pulse_distance_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import irpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int WORDS_PER_PHASE = 200;
  localparam int PHASES = 9;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid, in_ready;
  logic [DUR_W-1:0]      duration_us;
  logic                  frame_start;
  logic                  out_valid, out_ready;
  logic                  frame_ok;
  logic [VALUE_W-1:0]    data_value;
  logic [2:0]            status;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending, errors;

  // Registers as last written, used only to aim durations at the windows
  logic [CFG_DATA_W-1:0] cfg_shadow [0:6];
  bit                    calm;
  int                    frame_words;

  ir_pulse_distance_decoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .duration_us(duration_us), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_ok(frame_ok), .data_value(data_value), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  irpd_checker frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .duration_us(duration_us), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_ok(frame_ok), .data_value(data_value), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always #10 clk = ~clk;

  // Stall the result channel at random, except in the calm phase
  always @(negedge clk) out_ready <= calm || ($urandom_range(99, 0) >= 15);

  // Mark nominal gets the excess added, space nominal gets it taken off
  function automatic int unsigned eff_nom(input int unsigned nom, input bit is_mark);
    int unsigned ex;
    ex = cfg_shadow[REG_EXCESS][EXCESS_W-1:0];
    if (is_mark) return nom + ex;
    return (nom > ex) ? nom - ex : 0;
  endfunction

  // Pick a duration inside the window (edges often) or, for a miss, just past an edge or fully random
  function automatic logic [DUR_W-1:0] pick_dur(input int unsigned n, input bit miss);
    int unsigned t, lo, hi, d;
    t = cfg_shadow[REG_TOLERANCE][TOL_W-1:0];
    if (t > 100) t = 100;
    lo = (n * (100 - t)) / 100;
    hi = (n * (100 + t)) / 100;
    if (!miss) begin
      case ($urandom_range(5, 0))
        0:       d = lo;
        1:       d = hi;
        default: d = lo + $urandom_range(hi - lo, 0);
      endcase
    end else begin
      case ($urandom_range(3, 0))
        0:       d = (lo > 0) ? lo - 1 : hi + 1;
        1:       d = hi + 1;
        default: d = $urandom_range(65535, 0);
      endcase
    end
    return (d > 65535) ? 16'hFFFF : d[DUR_W-1:0];
  endfunction

  // Present one word and hold it until accepted; entered and left at a falling edge
  task automatic send_word(input logic [DUR_W-1:0] d, input logic start);
    int gap;
    if (!calm && $urandom_range(99, 0) < 15) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    duration_us <= d;
    frame_start <= start;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Send a frame; at slot cut either send a bad duration and stop, or just stop
  task automatic send_frame(input logic [VALUE_W-1:0] payload, input int cut,
                            input bit miss_at_cut);
    int unsigned n;
    for (int p = 0; p <= 2 * DATA_BITS + 1; p++) begin
      if (p == cut && !miss_at_cut) break;
      if (p == 0)
        n = eff_nom(cfg_shadow[REG_HDR_MARK], 1'b1);
      else if (p == 1)
        n = eff_nom(cfg_shadow[REG_HDR_SPACE], 1'b0);
      else if (p % 2 == 0)
        n = eff_nom(cfg_shadow[REG_BIT_MARK], 1'b1);
      else if (payload[DATA_BITS - 1 - (p - 3) / 2])
        n = eff_nom(cfg_shadow[REG_ONE_SPACE], 1'b0);
      else
        n = eff_nom(cfg_shadow[REG_ZERO_SPACE], 1'b0);
      send_word(pick_dur(n, p == cut), p == 0);
      frame_words++;
      if (p == cut) break;
    end
  endtask

  // Drop valid and hold off until every result has come, plus a short settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_EXCESS) cfg_shadow[idx] = val;
    @(negedge clk);
  endtask

  task automatic write_all(input int hm, input int hs, input int bm, input int os,
                           input int zs, input int tol, input int ex);
    write_reg(REG_HDR_MARK, CFG_DATA_W'(hm));
    write_reg(REG_HDR_SPACE, CFG_DATA_W'(hs));
    write_reg(REG_BIT_MARK, CFG_DATA_W'(bm));
    write_reg(REG_ONE_SPACE, CFG_DATA_W'(os));
    write_reg(REG_ZERO_SPACE, CFG_DATA_W'(zs));
    write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
    write_reg(REG_EXCESS, CFG_DATA_W'(ex));
  endtask

  // Register settings per phase: defaults, then the extremes, then random
  task automatic load_setting(input int k);
    case (k)
      0: begin
        write_all(RST_HDR_MARK, RST_HDR_SPACE, RST_BIT_MARK, RST_ONE_SPACE,
                  RST_ZERO_SPACE, RST_TOLERANCE, RST_EXCESS);
        write_reg(REG_NONE, 16'h1234);
      end
      1: write_all(9000, 4500, 560, 1690, 560, 0, 0);
      2: write_all(6000, 4500, 1000, 2000, 1000, 100, 1000);
      3: write_all(3000, 800, 500, 2500, 900, 127, 1023);
      4: write_all(65535, 0, 0, 65535, 0, 10, 0);
      5: write_all(65535, 65535, 65535, 40000, 20000, 50, 1000);
      default: write_all($urandom_range(20000, 100), $urandom_range(20000, 100),
                         $urandom_range(5000, 100), $urandom_range(8000, 100),
                         $urandom_range(8000, 100), $urandom_range(127, 0),
                         $urandom_range(1023, 0));
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_end;
    rst         = 1'b1;
    in_valid    = 1'b0;
    duration_us = '0;
    frame_start = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    calm        = 1'b0;
    frame_words = 0;
    cfg_shadow[REG_HDR_MARK]   = RST_HDR_MARK;
    cfg_shadow[REG_HDR_SPACE]  = RST_HDR_SPACE;
    cfg_shadow[REG_BIT_MARK]   = RST_BIT_MARK;
    cfg_shadow[REG_ONE_SPACE]  = RST_ONE_SPACE;
    cfg_shadow[REG_ZERO_SPACE] = RST_ZERO_SPACE;
    cfg_shadow[REG_TOLERANCE]  = CFG_DATA_W'(RST_TOLERANCE);
    cfg_shadow[REG_EXCESS]     = CFG_DATA_W'(RST_EXCESS);
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: header mark extremes, stray word, full frame, stop mark,
    // restart in mid-frame, header space miss
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_frame(8'hA5, -1, 1'b0);
    send_word(16'd600, 1'b0);
    send_frame(8'h00, 2, 1'b0);
    send_frame(8'hFF, 1, 1'b1);

    // Random frames under each register setting
    for (int k = 0; k < PHASES; k++) begin
      wait_drained();
      load_setting(k);
      calm = (k == 2);
      phase_end = frame_words + WORDS_PER_PHASE;
      while (frame_words < phase_end) begin
        case ($urandom_range(19, 0))
          0:       send_word(DUR_W'($urandom), 1'b0);
          1:       send_word(DUR_W'($urandom), 1'($urandom_range(1, 0)));
          2, 3, 4: send_frame(VALUE_W'($urandom), $urandom_range(2 * DATA_BITS + 1, 0), 1'b1);
          5:       send_frame(VALUE_W'($urandom), $urandom_range(2 * DATA_BITS + 1, 1), 1'b0);
          default: send_frame(VALUE_W'($urandom), -1, 1'b0);
        endcase
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("ir_pulse_distance_decoder_test: clean");
    end else begin
      $display("ir_pulse_distance_decoder_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10ms;
    $display("ir_pulse_distance_decoder_test: errors");
    $finish;
  end

endmodule
